### hw/rtl/fcw_pkg.sv
// Package for the face crop window calculator.
// Holds fixed-point widths, register indexes and the structs shared by
// the register block, the divider pipeline and the top level.
package fcw_pkg;

  localparam int FracBits = 12;
  localparam int MaxDim   = 4096;
  localparam int DimM1W   = $clog2(MaxDim);
  localparam int CfgDimW  = 13;
  localparam int ScaleW   = 16;
  localparam int NumW     = DimM1W + FracBits;
  localparam int DenW     = 14;
  localparam int CoordW   = 34;
  localparam int CutQ     = (18 * (1 << FracBits) + 50) / 100;
  localparam int AddrW    = 4;

  localparam logic [1:0] RegScale  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [DimM1W-1:0] wm1;
    logic [DimM1W-1:0] hm1;
  } cfg_t;

  typedef struct packed {
    logic signed [12:0] x;
    logic [12:0]        w;
    logic signed [14:0] ny;
    logic [13:0]        nh;
    logic               bad;
  } side_t;

  typedef struct packed {
    logic [NumW-1:0] num_h;
    logic [DenW-1:0] den_h;
    logic [NumW-1:0] num_w;
    logic [DenW-1:0] den_w;
    side_t           side;
  } div_in_t;

  typedef struct packed {
    logic [NumW-1:0] q_h;
    logic [NumW-1:0] q_w;
    side_t           side;
  } div_out_t;

endpackage

### hw/rtl/fcw_box_if.sv
// Input channel carrying one detected face box per word.
// Uses no package; valid/ready handshake.
interface fcw_box_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] box_x;
  logic signed [12:0] box_y;
  logic signed [13:0] box_w;
  logic signed [13:0] box_h;

  modport source (output valid, box_x, box_y, box_w, box_h, input ready);
  modport sink (input valid, box_x, box_y, box_w, box_h, output ready);
endinterface

### hw/rtl/fcw_crop_if.sv
// Output channel carrying one crop window per word.
// Uses no package; valid/ready handshake.
interface fcw_crop_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] crop_x;
  logic signed [12:0] crop_y;
  logic [13:0]        crop_width;
  logic [13:0]        crop_height;
  logic               bad_box;

  modport source (output valid, crop_x, crop_y, crop_width, crop_height, bad_box,
                  input ready);
  modport sink (input valid, crop_x, crop_y, crop_width, crop_height, bad_box,
                output ready);
endinterface

### hw/rtl/fcw_apb_regs.sv
// APB configuration registers: scale limit, image width and image height.
// Depends on fcw_pkg; presents the clamped image sizes minus one.
module fcw_apb_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [fcw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output fcw_pkg::cfg_t            cfg_o
);

  logic [fcw_pkg::ScaleW-1:0]  scale_q;
  logic [fcw_pkg::CfgDimW-1:0] width_q;
  logic [fcw_pkg::CfgDimW-1:0] height_q;
  logic                        wr_en;
  logic [1:0]                  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= fcw_pkg::ScaleW'(4096);
      width_q  <= fcw_pkg::CfgDimW'(1920);
      height_q <= fcw_pkg::CfgDimW'(1080);
    end else if (wr_en) begin
      unique case (idx)
        fcw_pkg::RegScale:  scale_q  <= pwdata[fcw_pkg::ScaleW-1:0];
        fcw_pkg::RegWidth:  width_q  <= pwdata[fcw_pkg::CfgDimW-1:0];
        fcw_pkg::RegHeight: height_q <= pwdata[fcw_pkg::CfgDimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fcw_pkg::RegScale:  prdata = 32'(scale_q);
      fcw_pkg::RegWidth:  prdata = 32'(width_q);
      fcw_pkg::RegHeight: prdata = 32'(height_q);
      default:            prdata = 32'd0;
    endcase
  end

  function automatic logic [fcw_pkg::DimM1W-1:0] dim_m1(logic [fcw_pkg::CfgDimW-1:0] v);
    logic [fcw_pkg::CfgDimW-1:0] c;
    if (v < fcw_pkg::CfgDimW'(2)) c = fcw_pkg::CfgDimW'(2);
    else if (v > fcw_pkg::CfgDimW'(fcw_pkg::MaxDim)) c = fcw_pkg::CfgDimW'(fcw_pkg::MaxDim);
    else c = v;
    return fcw_pkg::DimM1W'(c - fcw_pkg::CfgDimW'(1));
  endfunction

  assign cfg_o.scale = scale_q;
  assign cfg_o.wm1   = dim_m1(width_q);
  assign cfg_o.hm1   = dim_m1(height_q);

endmodule

### hw/rtl/fcw_div_pipe.sv
// Two restoring dividers side by side, one quotient bit per stage.
// Depends on fcw_pkg; side data travels with each word.
module fcw_div_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fcw_pkg::div_in_t   data_i,
  output logic               valid_o,
  output fcw_pkg::div_out_t  data_o
);

  localparam int N = fcw_pkg::NumW;
  localparam int D = fcw_pkg::DenW;

  logic          valid_q [N];
  logic [N-1:0]  num_q   [N][2];
  logic [D-1:0]  den_q   [N][2];
  logic [D-1:0]  rem_q   [N][2];
  logic [N-1:0]  quo_q   [N][2];
  fcw_pkg::side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          v_prev;
    logic [N-1:0]  n_prev [2];
    logic [D-1:0]  d_prev [2];
    logic [D-1:0]  r_prev [2];
    logic [N-1:0]  q_prev [2];
    fcw_pkg::side_t s_prev;

    if (k == 0) begin : g_first
      assign v_prev    = valid_i;
      assign n_prev[0] = data_i.num_h;
      assign n_prev[1] = data_i.num_w;
      assign d_prev[0] = data_i.den_h;
      assign d_prev[1] = data_i.den_w;
      assign r_prev[0] = '0;
      assign r_prev[1] = '0;
      assign q_prev[0] = '0;
      assign q_prev[1] = '0;
      assign s_prev    = data_i.side;
    end else begin : g_next
      assign v_prev    = valid_q[k-1];
      assign n_prev[0] = num_q[k-1][0];
      assign n_prev[1] = num_q[k-1][1];
      assign d_prev[0] = den_q[k-1][0];
      assign d_prev[1] = den_q[k-1][1];
      assign r_prev[0] = rem_q[k-1][0];
      assign r_prev[1] = rem_q[k-1][1];
      assign q_prev[0] = quo_q[k-1][0];
      assign q_prev[1] = quo_q[k-1][1];
      assign s_prev    = side_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [D:0] trial;
      logic       ge;
      assign trial = {r_prev[l], n_prev[l][N-1-k]};
      assign ge    = trial >= {1'b0, d_prev[l]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[k][l] <= n_prev[l];
          den_q[k][l] <= d_prev[l];
          rem_q[k][l] <= ge ? D'(trial - {1'b0, d_prev[l]}) : D'(trial);
          quo_q[k][l] <= {q_prev[l][N-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_prev;
      end
    end
  end

  assign valid_o     = valid_q[N-1];
  assign data_o.q_h  = quo_q[N-1][0];
  assign data_o.q_w  = quo_q[N-1][1];
  assign data_o.side = side_q[N-1];

endmodule

### hw/rtl/face_crop_window_calc_core.sv
// Top level of the face crop window calculator.
// Depends on fcw_pkg, fcw_box_if, fcw_crop_if, fcw_apb_regs and fcw_div_pipe.
//
//   Channel   Direction  Handshake           Contents
//   box_i     in         valid/ready         box_x, box_y, box_w, box_h
//   crop_o    out        valid/ready         crop_x, crop_y, crop_width, crop_height, bad_box
//   APB       in/out     psel/penable        scale_limit, image_width, image_height
//
// One word is accepted per cycle while the output is not held; each result passes
// through the 24 one-bit stages of the divider pipeline plus seven arithmetic stages.
// Reset clears all valid bits and loads the register defaults.
// A held result at the output freezes the whole pipeline, and box_i.ready drops
// in that same cycle, so nothing is lost or repeated.
module face_crop_window_calc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fcw_box_if.sink                   box_i,
  fcw_crop_if.source                crop_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int F  = fcw_pkg::FracBits;
  localparam int CW = fcw_pkg::CoordW;
  localparam int SW = fcw_pkg::ScaleW;
  localparam int N  = fcw_pkg::NumW;

  fcw_pkg::cfg_t cfg;
  logic          en;

  fcw_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign en          = !crop_o.valid || crop_o.ready;
  assign box_i.ready = en;

  // Stage 1: top cut offset.
  logic signed [24:0] hprod;
  logic signed [13:0] t_d;
  logic               p1_v_q;
  logic signed [12:0] p1_x_q, p1_y_q;
  logic signed [13:0] p1_w_q, p1_h_q, p1_t_q;

  assign hprod = 25'(box_i.box_h) * 25'(fcw_pkg::CutQ);
  assign t_d   = 14'((hprod + (hprod[24] ? 25'((1 << F) - 1) : 25'sd0)) >>> F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_x_q <= box_i.box_x;
      p1_y_q <= box_i.box_y;
      p1_w_q <= box_i.box_w;
      p1_h_q <= box_i.box_h;
      p1_t_q <= t_d;
    end
  end

  // Stage 2: adjusted top and height, divider operands.
  logic signed [14:0] ny0, ny, hm1_s;
  logic signed [15:0] nh;
  logic               bad;
  fcw_pkg::div_in_t   div_in;
  fcw_pkg::div_out_t  div_out;
  logic               div_v;
  logic               p2_v_q;
  fcw_pkg::div_in_t   p2_q;

  assign hm1_s = 15'(signed'({1'b0, cfg.hm1}));
  assign ny0   = 15'(p1_y_q) + 15'(p1_t_q);
  assign ny    = (ny0 > hm1_s) ? hm1_s : ny0;
  assign nh    = 16'(p1_y_q) + 16'(p1_h_q) - 16'(ny);
  assign bad   = (p1_w_q <= 14'sd0) || (nh <= 16'sd0);

  assign div_in.num_h    = N'(cfg.hm1) << F;
  assign div_in.num_w    = N'(cfg.wm1) << F;
  assign div_in.den_h    = bad ? 14'd1 : nh[13:0];
  assign div_in.den_w    = bad ? 14'd1 : {1'b0, p1_w_q[12:0]};
  assign div_in.side.x   = p1_x_q;
  assign div_in.side.w   = p1_w_q[12:0];
  assign div_in.side.ny  = ny;
  assign div_in.side.nh  = nh[13:0];
  assign div_in.side.bad = bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= div_in;
    end
  end

  fcw_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(p2_v_q),
    .data_i (p2_q),
    .valid_o(div_v),
    .data_o (div_out)
  );

  // Stage 3: scale factor and doubled centers.
  logic [SW-1:0]      s_a, s_d;
  logic signed [15:0] cxb_d;
  logic signed [16:0] cyb_d;
  logic               p3_v_q, p3_bad_q;
  logic [SW-1:0]      p3_s_q;
  logic [12:0]        p3_w_q;
  logic [13:0]        p3_nh_q;
  logic signed [15:0] p3_cxb_q;
  logic signed [16:0] p3_cyb_q;

  assign s_a   = (N'(cfg.scale) > div_out.q_h) ? SW'(div_out.q_h) : cfg.scale;
  assign s_d   = (N'(s_a) > div_out.q_w) ? SW'(div_out.q_w) : s_a;
  assign cxb_d = (16'(div_out.side.x) <<< 1) + 16'(signed'({1'b0, div_out.side.w}));
  assign cyb_d = (17'(div_out.side.ny) <<< 1) + 17'(signed'({1'b0, div_out.side.nh}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_bad_q <= div_out.side.bad;
      p3_s_q   <= s_d;
      p3_w_q   <= div_out.side.w;
      p3_nh_q  <= div_out.side.nh;
      p3_cxb_q <= cxb_d;
      p3_cyb_q <= cyb_d;
    end
  end

  // Stage 4: half sizes.
  logic               p4_v_q, p4_bad_q;
  logic [28:0]        p4_hw_q;
  logic [29:0]        p4_hh_q;
  logic signed [CW-1:0] p4_cx_q, p4_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_bad_q <= p3_bad_q;
      p4_hw_q  <= 29'(p3_w_q) * 29'(p3_s_q);
      p4_hh_q  <= 30'(p3_nh_q) * 30'(p3_s_q);
      p4_cx_q  <= CW'(p3_cxb_q) <<< F;
      p4_cy_q  <= CW'(p3_cyb_q) <<< F;
    end
  end

  // Stage 5: corners, pushed in from the left and top borders.
  logic signed [CW-1:0] hw_s, hh_s, lx0, rx0, ty0, by0;
  logic                 p5_v_q, p5_bad_q;
  logic signed [CW-1:0] p5_lx_q, p5_rx_q, p5_ty_q, p5_by_q;

  assign hw_s = CW'(p4_hw_q);
  assign hh_s = CW'(p4_hh_q);
  assign lx0  = p4_cx_q - hw_s;
  assign rx0  = p4_cx_q + hw_s;
  assign ty0  = p4_cy_q - hh_s;
  assign by0  = p4_cy_q + hh_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_bad_q <= p4_bad_q;
      p5_lx_q  <= (lx0 < 0) ? '0 : lx0;
      p5_rx_q  <= (lx0 < 0) ? (hw_s <<< 1) : rx0;
      p5_ty_q  <= (ty0 < 0) ? '0 : ty0;
      p5_by_q  <= (ty0 < 0) ? (hh_s <<< 1) : by0;
    end
  end

  // Stage 6: pushed in from the right and bottom borders.
  logic signed [CW-1:0] limx, limy;
  logic                 p6_v_q, p6_bad_q;
  logic signed [CW-1:0] p6_lx_q, p6_rx_q, p6_ty_q, p6_by_q;

  assign limx = CW'(cfg.wm1) <<< (F + 1);
  assign limy = CW'(cfg.hm1) <<< (F + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_v_q <= 1'b0;
    end else if (en) begin
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_bad_q <= p5_bad_q;
      p6_lx_q  <= (p5_rx_q > limx) ? (p5_lx_q - p5_rx_q + limx) : p5_lx_q;
      p6_rx_q  <= (p5_rx_q > limx) ? limx : p5_rx_q;
      p6_ty_q  <= (p5_by_q > limy) ? (p5_ty_q - p5_by_q + limy) : p5_ty_q;
      p6_by_q  <= (p5_by_q > limy) ? limy : p5_by_q;
    end
  end

  // Stage 7: truncation to whole pixels into the output register.
  localparam logic signed [CW-1:0] TruncMask = CW'((1 << (F + 1)) - 1);
  localparam logic signed [CW-1:0] TwoOne    = CW'(2 << F);

  logic signed [CW-1:0] xs, ys, ws, hs;
  logic                 out_v_q;

  assign xs = (p6_lx_q + ((p6_lx_q < 0) ? TruncMask : '0)) >>> (F + 1);
  assign ys = (p6_ty_q + ((p6_ty_q < 0) ? TruncMask : '0)) >>> (F + 1);
  assign ws = (p6_rx_q - p6_lx_q + TwoOne) >>> (F + 1);
  assign hs = (p6_by_q - p6_ty_q + TwoOne) >>> (F + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crop_o.bad_box     <= p6_bad_q;
      crop_o.crop_x      <= p6_bad_q ? 13'sd0 : 13'(xs);
      crop_o.crop_y      <= p6_bad_q ? 13'sd0 : 13'(ys);
      crop_o.crop_width  <= p6_bad_q ? 14'd0 : 14'(ws);
      crop_o.crop_height <= p6_bad_q ? 14'd0 : 14'(hs);
    end
  end

  assign crop_o.valid = out_v_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crop_o.valid && crop_o.bad_box |->
      crop_o.crop_x == 13'sd0 && crop_o.crop_y == 13'sd0 &&
      crop_o.crop_width == 14'd0 && crop_o.crop_height == 14'd0)
    else $error("bad box word carries a nonzero window");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crop_o.valid && !crop_o.bad_box |->
      crop_o.crop_width != 14'd0 && crop_o.crop_height != 14'd0)
    else $error("good window has zero size");

  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crop_o.valid && !crop_o.bad_box |-> !crop_o.crop_x[12] && !crop_o.crop_y[12])
    else $error("window corner left the image");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crop_o.valid && !crop_o.ready |-> !box_i.ready)
    else $error("input taken while output is held");

endmodule

### tb/tb.sv
// Testbench for face_crop_window_calc_core: drives face boxes, programs the
// APB registers and checks each crop window against an in-bench predictor.
// Depends on fcw_pkg, fcw_box_if, fcw_crop_if and the RTL top level.
`timescale 1ns / 100ps

module tb;

  localparam int LatCycles = 40;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [13:0] w;
    logic signed [13:0] h;
  } box_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
    logic        bad;
  } crop_t;

  typedef struct {
    box_t  box;
    logic  typed;
    crop_t crop;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fcw_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fcw_box_if  box_ch ();
  fcw_crop_if crop_ch ();

  face_crop_window_calc_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_ch.sink),
    .crop_o  (crop_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint unsigned cur_scale, cur_width, cur_height;
  crop_t crop_queue[$];
  int unsigned fails = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint unsigned cycle_count = 0;

  function automatic longint div_trunc_q(longint v, int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic longint sat_dim(longint unsigned v);
    if (v < 2) return 2;
    if (v > fcw_pkg::MaxDim) return fcw_pkg::MaxDim;
    return longint'(v);
  endfunction

  function automatic crop_t crop_window(box_t b);
    crop_t r;
    longint x, y, w, h, wm1, hm1, ny, nh, s, q, cx, cy, hw, hh;
    longint lx, rx, ty, by, limx, limy, one;
    one = longint'(1) << fcw_pkg::FracBits;
    x = b.x; y = b.y; w = b.w; h = b.h;
    wm1 = sat_dim(cur_width) - 1;
    hm1 = sat_dim(cur_height) - 1;
    ny = y + div_trunc_q(h * fcw_pkg::CutQ, fcw_pkg::FracBits);
    if (ny > hm1) ny = hm1;
    nh = y + h - ny;
    r = '0;
    if (w <= 0 || nh <= 0) begin
      r.bad = 1'b1;
      return r;
    end
    s = longint'(cur_scale);
    q = (hm1 * one) / nh;
    if (q < s) s = q;
    q = (wm1 * one) / w;
    if (q < s) s = q;
    cx = (2 * x + w) * one;
    cy = (2 * ny + nh) * one;
    hw = w * s;
    hh = nh * s;
    lx = cx - hw; rx = cx + hw; ty = cy - hh; by = cy + hh;
    limx = wm1 * 2 * one;
    limy = hm1 * 2 * one;
    if (lx < 0) begin rx -= lx; lx = 0; end
    if (ty < 0) begin by -= ty; ty = 0; end
    if (rx > limx) begin lx -= rx - limx; rx = limx; end
    if (by > limy) begin ty -= by - limy; by = limy; end
    r.x = 13'(div_trunc_q(lx, fcw_pkg::FracBits + 1));
    r.y = 13'(div_trunc_q(ty, fcw_pkg::FracBits + 1));
    r.w = 14'(div_trunc_q(rx - lx + 2 * one, fcw_pkg::FracBits + 1));
    r.h = 14'(div_trunc_q(by - ty + 2 * one, fcw_pkg::FracBits + 1));
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off)
      crop_ch.ready <= 1'b0;
    else
      crop_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial crop_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    crop_t got, want;
    if (rst_ni && crop_ch.valid && crop_ch.ready) begin
      got = {crop_ch.crop_x, crop_ch.crop_y, crop_ch.crop_width,
             crop_ch.crop_height, crop_ch.bad_box};
      if (crop_queue.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        fails++;
      end else begin
        want = crop_queue.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected x=%0d y=%0d w=%0d h=%0d bad=%b", $time,
                   $signed(want.x), $signed(want.y), want.w, want.h, want.bad);
          $display("%0t          actual   x=%0d y=%0d w=%0d h=%0d bad=%b", $time,
                   $signed(got.x), $signed(got.y), got.w, got.h, got.bad);
          fails++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= fcw_pkg::AddrW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      fcw_pkg::RegScale:  cur_scale = val & 32'hFFFF;
      fcw_pkg::RegWidth:  cur_width = val & 32'h1FFF;
      fcw_pkg::RegHeight: cur_height = val & 32'h1FFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    box_ch.valid <= 1'b0;
    while (crop_queue.size() != 0) @(posedge clk_i);
    repeat (LatCycles) @(posedge clk_i);
  endtask

  task automatic send_box(box_t b, logic typed, crop_t typed_crop);
    crop_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    box_ch.valid <= 1'b1;
    {box_ch.box_x, box_ch.box_y, box_ch.box_w, box_ch.box_h} <= b;
    want = crop_window(b);
    if (typed && typed_crop !== want) begin
      $display("%0t typed row disagrees with predictor: expected %h actual %h",
               $time, typed_crop, want);
      fails++;
    end
    if (typed) want = typed_crop;
    do @(posedge clk_i); while (!box_ch.ready);
    crop_queue = {crop_queue, want};
  endtask

  function automatic box_t random_box();
    box_t b;
    int unsigned mode;
    mode = $urandom_range(9);
    b.x = 13'($urandom);
    b.y = 13'($urandom);
    if (mode < 6) begin
      b.x = 13'($urandom_range(2000));
      b.y = 13'($urandom_range(1500));
      b.w = 14'($urandom_range(1, 600));
      b.h = 14'($urandom_range(1, 700));
    end else if (mode < 8) begin
      b.w = 14'($urandom_range(1, 4096));
      b.h = 14'($urandom_range(1, 4096));
    end else begin
      b.w = 14'($signed($urandom_range(8192)) - 4096);
      b.h = 14'($signed($urandom_range(8192)) - 4096);
    end
    return b;
  endfunction

  row_t rows[$];

  task automatic add_row(int x, int y, int w, int h, logic typed = 1'b0,
                         crop_t c = '0);
    row_t r;
    r.box = {13'(x), 13'(y), 14'(w), 14'(h)};
    r.typed = typed;
    r.crop = c;
    rows = {rows, r};
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_box(random_box(), 1'b0, '0);
    drain();
  endtask

  initial begin
    box_ch.valid = 1'b0;
    box_ch.box_x = '0; box_ch.box_y = '0;
    box_ch.box_w = '0; box_ch.box_h = '0;
    cur_scale = 4096; cur_width = 1920; cur_height = 1080;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(0, 0, 0, 100, 1'b1, crop_t'(1));
    add_row(0, 0, 100, 0, 1'b1, crop_t'(1));
    add_row(0, 0, -4096, -4096, 1'b1, crop_t'(1));
    add_row(4095, 4095, 4096, 4096);
    add_row(-4096, -4096, 4096, 4096);
    add_row(100, 100, 200, 200);
    add_row(0, 0, 1, 1);
    add_row(-4096, 4095, 4096, 1);
    add_row(1800, 1000, 300, 300);
    add_row(-50, -50, 100, 120);
    add_row(500, 1070, 50, 50);
    add_row(10, 10, 4096, 4096);
    add_row(4095, -4096, 1, 4096);
    foreach (rows[i]) send_box(rows[i].box, rows[i].typed, rows[i].crop);
    drain();

    reg_write(fcw_pkg::RegScale, 32'd8192);
    reg_write(fcw_pkg::RegWidth, 32'd640);
    reg_write(fcw_pkg::RegHeight, 32'd480);
    random_phase(150, 0, 0);

    reg_write(fcw_pkg::RegScale, 32'hFFFF);
    reg_write(fcw_pkg::RegWidth, 32'd4096);
    reg_write(fcw_pkg::RegHeight, 32'd4096);
    random_phase(150, 46, 0);

    reg_write(fcw_pkg::RegScale, 32'd0);
    reg_write(fcw_pkg::RegWidth, 32'd2);
    reg_write(fcw_pkg::RegHeight, 32'd2);
    random_phase(60, 0, 46);

    reg_write(fcw_pkg::RegScale, 32'd6000);
    reg_write(fcw_pkg::RegWidth, 32'h1FFF);
    reg_write(fcw_pkg::RegHeight, 32'd0);
    random_phase(60, 0, 46);

    reg_write(fcw_pkg::RegScale, 32'd5000);
    reg_write(fcw_pkg::RegWidth, 32'd1920);
    reg_write(fcw_pkg::RegHeight, 32'd1080);
    random_phase(100, 17, 17);

    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(80, 0, 0);
    join

    drain();
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_box_if.sv
hw/rtl/fcw_crop_if.sv
hw/rtl/fcw_apb_regs.sv
hw/rtl/fcw_div_pipe.sv
hw/rtl/face_crop_window_calc_core.sv
tb/tb.sv
